// File: rtl/dtlr_pkg.sv
// Shared types, sizes and helper functions for the depth-tested line rasterizer.
// No dependencies; used by rtl/depth_tested_line_rasterizer.sv.
package dtlr_pkg;

  localparam int MAX_WIDTH  = 320;
  localparam int MAX_HEIGHT = 240;
  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);

  localparam int WIDTH_W  = 9;
  localparam int HEIGHT_W = 8;
  localparam int VAL_W    = 12;
  localparam int STEPS_W  = 12;
  localparam int SQ_W     = 24;
  localparam int NUM_LANES = 6;
  localparam int LANE_W   = $clog2(NUM_LANES);
  localparam int ITER_W   = 4;
  localparam int SQRT_ITERS = SQ_W / 2;
  localparam int DIV_ITERS  = VAL_W;

  localparam logic [1:0] ACT_DRAW  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  localparam logic [15:0] CLEAR_COLOR = 16'd0;
  localparam logic [7:0]  CLEAR_DEPTH = 8'd255;

  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = WIDTH_W'(320);
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = HEIGHT_W'(240);

  // Lane order of the interpolated attributes.
  localparam logic [LANE_W-1:0] LANE_X = LANE_W'(0);
  localparam logic [LANE_W-1:0] LANE_Y = LANE_W'(1);
  localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(NUM_LANES - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_ADJ,
    ST_DIVLOAD,
    ST_DIV,
    ST_DIVFIX,
    ST_PT_ADDR,
    ST_PT_READ,
    ST_PT_TEST,
    ST_RD_ADDR,
    ST_RD_MEM,
    ST_RD_DATA,
    ST_FINISH
  } state_t;

  // Scales one 8-bit channel to 5 or 6 bits as (c*scale+127)/255, truncating.
  // The division by 255 is (x+1)*257 >> 16, exact for the range used here.
  function automatic logic [5:0] scale_chan(input logic [7:0] c, input logic [5:0] scale);
    logic [13:0] x;
    logic [22:0] y;
    x = 14'(c) * 14'(scale) + 14'd127;
    y = 23'({9'd0, x} + 23'd1) * 23'd257;
    return y[21:16];
  endfunction

  function automatic logic [15:0] to_rgb565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
    logic [5:0] r5;
    logic [5:0] g6;
    logic [5:0] b5;
    r5 = scale_chan(r, 6'd31);
    g6 = scale_chan(g, 6'd63);
    b5 = scale_chan(b, 6'd31);
    return {r5[4:0], g6, b5[4:0]};
  endfunction

  // Value q + r/s rounded half away from zero, with 0 <= r < s.
  function automatic logic [VAL_W:0] round_lane(input logic [VAL_W-1:0] q,
                                                input logic [STEPS_W-1:0] r,
                                                input logic [STEPS_W-1:0] s);
    logic [STEPS_W:0] r2;
    logic up;
    r2 = {r, 1'b0};
    up = (r2 > {1'b0, s}) || ((r2 == {1'b0, s}) && !q[VAL_W-1]);
    return {q[VAL_W-1], q} + {{VAL_W{1'b0}}, up};
  endfunction

endpackage

// File: rtl/depth_tested_line_rasterizer.sv
// Top level of the depth-tested line rasterizer: control, arithmetic and both stores.
// Depends on rtl/dtlr_pkg.sv.
//
// The block keeps a 320 by 240 RGB565 frame store and an 8-bit depth store. After reset,
// and for every clear word, it sweeps both stores one pixel a cycle; during the sweep no
// input word is taken, though configuration writes are. A draw word first finds the step
// count with one shared 12 by 12 multiplier and a two-bits-a-cycle square root, then,
// unless the step count is zero, sets up six interpolation lanes with one shared restoring
// divider, and then walks the line point by point, as each point needs an address, a depth
// read and a conditional write through the single store port. The block takes one input
// word at a time; a finished result sits in an output register, so the next word is taken
// while that result waits.
module depth_tested_line_rasterizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  action,
  input  logic signed [10:0] start_x,
  input  logic signed [10:0] start_y,
  input  logic [7:0]  start_depth,
  input  logic [23:0] start_color,
  input  logic signed [10:0] end_x,
  input  logic signed [10:0] end_y,
  input  logic [7:0]  end_depth,
  input  logic [23:0] end_color,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [15:0] read_color,
  output logic [7:0]  read_depth,
  output logic [11:0] pixels_written,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int VW = dtlr_pkg::VAL_W;
  localparam int SW = dtlr_pkg::STEPS_W;
  localparam int AW = dtlr_pkg::ADDR_W;
  localparam int NL = dtlr_pkg::NUM_LANES;

  dtlr_pkg::state_t state, state_next;

  // Configuration registers and their clamped forms.
  logic [dtlr_pkg::WIDTH_W-1:0]  area_width;
  logic [dtlr_pkg::HEIGHT_W-1:0] area_height;
  logic [dtlr_pkg::WIDTH_W-1:0]  w_eff;
  logic [dtlr_pkg::HEIGHT_W-1:0] h_eff;

  // Latched endpoints, one lane per attribute: x, y, depth, red, green, blue.
  logic [1:0]    act;
  logic [VW-1:0] lane_a [NL];
  logic [VW-1:0] lane_b [NL];

  // Interpolation state: value is q + r/sdiv, advanced by step_q + step_r/sdiv.
  logic [VW-1:0] lane_q [NL];
  logic [SW-1:0] lane_r [NL];
  logic [VW-1:0] step_q [NL];
  logic [SW-1:0] step_r [NL];
  logic [VW-1:0] lane_q_adv [NL];
  logic [SW-1:0] lane_r_adv [NL];
  logic [VW:0]   lane_val [NL];

  // Step count and the square root that finds it.
  logic [dtlr_pkg::SQ_W-1:0] dsq;
  logic [SW-1:0]  root;
  logic [SW+1:0]  sq_rem;
  logic [SW+3:0]  sq_rsh;
  logic [SW+1:0]  sq_trial;
  logic [SW-1:0]  steps;
  logic [SW-1:0]  steps_next;
  logic [SW-1:0]  sdiv;
  logic [SW-1:0]  k;
  logic [dtlr_pkg::ITER_W-1:0] iter;

  // Shared divider.
  logic [dtlr_pkg::LANE_W-1:0] lane;
  logic [VW-1:0] diff_sel;
  logic [VW-1:0] diff_mag;
  logic [VW-1:0] dvd;
  logic [SW-1:0] drem;
  logic [SW:0]   div_rsh;

  // Shared multiplier.
  logic [VW-1:0] mul_a;
  logic [VW-1:0] mul_b;
  logic [2*VW-1:0] mul_p;
  logic [VW-1:0] mag_x;
  logic [VW-1:0] mag_y;

  // Point stage.
  logic [VW:0]   pos_x;
  logic [VW:0]   pos_y;
  logic          pos_in;
  logic [AW-1:0] pt_addr;
  logic          pt_ok;
  logic [7:0]    pt_z;
  logic [15:0]   pt_color;
  logic          pt_hit;

  // Clearing sweep.
  logic [AW-1:0] clr_addr;
  logic          clr_reply;

  // Result being built.
  logic [15:0] res_color;
  logic [7:0]  res_depth;
  logic [11:0] res_count;

  // Stores.
  logic [15:0] frame_mem [dtlr_pkg::STORE_SIZE];
  logic [7:0]  depth_mem [dtlr_pkg::STORE_SIZE];
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [15:0]   mem_wcolor;
  logic [7:0]    mem_wdepth;
  logic [15:0]   color_rd;
  logic [7:0]    depth_rd;

  logic out_free;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != dtlr_pkg::ST_IDLE);
  assign out_free   = !result_valid || !result_stall;

  assign w_eff = (area_width > dtlr_pkg::WIDTH_W'(dtlr_pkg::MAX_WIDTH)) ?
                 dtlr_pkg::WIDTH_W'(dtlr_pkg::MAX_WIDTH) : area_width;
  assign h_eff = (area_height > dtlr_pkg::HEIGHT_W'(dtlr_pkg::MAX_HEIGHT)) ?
                 dtlr_pkg::HEIGHT_W'(dtlr_pkg::MAX_HEIGHT) : area_height;

  // Endpoint differences as magnitudes for the squares.
  always_comb begin
    logic [VW-1:0] dx;
    logic [VW-1:0] dy;
    dx = lane_b[dtlr_pkg::LANE_X] - lane_a[dtlr_pkg::LANE_X];
    dy = lane_b[dtlr_pkg::LANE_Y] - lane_a[dtlr_pkg::LANE_Y];
    mag_x = dx[VW-1] ? (~dx + VW'(1)) : dx;
    mag_y = dy[VW-1] ? (~dy + VW'(1)) : dy;
  end

  // The one multiplier serves the squared length and the pixel address.
  always_comb begin
    case (state)
      dtlr_pkg::ST_SQX: begin
        mul_a = mag_x;
        mul_b = mag_x;
      end
      dtlr_pkg::ST_SQY: begin
        mul_a = mag_y;
        mul_b = mag_y;
      end
      default: begin
        mul_a = {{(VW-8){1'b0}}, pos_y[7:0]};
        mul_b = {{(VW-dtlr_pkg::WIDTH_W){1'b0}}, w_eff};
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Square root, two bits of the radicand per cycle.
  assign sq_rsh   = {sq_rem, dsq[dtlr_pkg::SQ_W-1 -: 2]};
  assign sq_trial = {root, 2'b01};
  assign steps_next = (sq_rem > {2'b00, root}) ? (root + SW'(1)) : root;

  // Divider: one quotient bit per cycle.
  assign diff_sel = lane_b[lane] - lane_a[lane];
  assign diff_mag = diff_sel[VW-1] ? (~diff_sel + VW'(1)) : diff_sel;
  assign div_rsh  = {drem, dvd[VW-1]};

  // Lanes: rounded value at this point, and the value at the next one.
  always_comb begin
    logic [SW:0] rs;
    for (int l = 0; l < NL; l++) begin
      lane_val[l] = dtlr_pkg::round_lane(lane_q[l], lane_r[l], sdiv);
      rs = {1'b0, lane_r[l]} + {1'b0, step_r[l]};
      if (rs >= {1'b0, sdiv}) begin
        lane_r_adv[l] = SW'(rs - {1'b0, sdiv});
        lane_q_adv[l] = lane_q[l] + step_q[l] + VW'(1);
      end else begin
        lane_r_adv[l] = SW'(rs);
        lane_q_adv[l] = lane_q[l] + step_q[l];
      end
    end
  end

  // Bounds test on either the line point or the read position.
  always_comb begin
    if (state == dtlr_pkg::ST_RD_ADDR) begin
      pos_x = {lane_a[dtlr_pkg::LANE_X][VW-1], lane_a[dtlr_pkg::LANE_X]};
      pos_y = {lane_a[dtlr_pkg::LANE_Y][VW-1], lane_a[dtlr_pkg::LANE_Y]};
    end else begin
      pos_x = lane_val[dtlr_pkg::LANE_X];
      pos_y = lane_val[dtlr_pkg::LANE_Y];
    end
    pos_in = !pos_x[VW] && (pos_x[VW-1:0] < {{(VW-dtlr_pkg::WIDTH_W){1'b0}}, w_eff}) &&
             !pos_y[VW] && (pos_y[VW-1:0] < {{(VW-dtlr_pkg::HEIGHT_W){1'b0}}, h_eff});
  end

  // A point is written only when strictly nearer than what is stored.
  assign pt_hit = pt_ok && (pt_z < depth_rd);

  // Store port.
  always_comb begin
    if (state == dtlr_pkg::ST_CLEAR) begin
      mem_addr   = clr_addr;
      mem_we     = 1'b1;
      mem_wcolor = dtlr_pkg::CLEAR_COLOR;
      mem_wdepth = dtlr_pkg::CLEAR_DEPTH;
    end else begin
      mem_addr   = pt_addr;
      mem_we     = (state == dtlr_pkg::ST_PT_TEST) && pt_hit;
      mem_wcolor = pt_color;
      mem_wdepth = pt_z;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_addr] <= mem_wcolor;
      depth_mem[mem_addr] <= mem_wdepth;
    end
    color_rd <= frame_mem[mem_addr];
    depth_rd <= depth_mem[mem_addr];
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      dtlr_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(dtlr_pkg::STORE_SIZE - 1)) begin
          state_next = clr_reply ? dtlr_pkg::ST_FINISH : dtlr_pkg::ST_IDLE;
        end
      end
      dtlr_pkg::ST_IDLE: begin
        if (item_valid) begin
          case (action)
            dtlr_pkg::ACT_DRAW:  state_next = dtlr_pkg::ST_SQX;
            dtlr_pkg::ACT_READ:  state_next = dtlr_pkg::ST_RD_ADDR;
            dtlr_pkg::ACT_CLEAR: state_next = dtlr_pkg::ST_CLEAR;
            default:             state_next = dtlr_pkg::ST_FINISH;
          endcase
        end
      end
      dtlr_pkg::ST_SQX: state_next = dtlr_pkg::ST_SQY;
      dtlr_pkg::ST_SQY: state_next = dtlr_pkg::ST_SQRT;
      dtlr_pkg::ST_SQRT: begin
        if (iter == dtlr_pkg::ITER_W'(dtlr_pkg::SQRT_ITERS - 1)) begin
          state_next = dtlr_pkg::ST_ADJ;
        end
      end
      dtlr_pkg::ST_ADJ: begin
        state_next = (steps_next == '0) ? dtlr_pkg::ST_PT_ADDR : dtlr_pkg::ST_DIVLOAD;
      end
      dtlr_pkg::ST_DIVLOAD: state_next = dtlr_pkg::ST_DIV;
      dtlr_pkg::ST_DIV: begin
        if (iter == dtlr_pkg::ITER_W'(dtlr_pkg::DIV_ITERS - 1)) begin
          state_next = dtlr_pkg::ST_DIVFIX;
        end
      end
      dtlr_pkg::ST_DIVFIX: begin
        state_next = (lane == dtlr_pkg::LANE_LAST) ? dtlr_pkg::ST_PT_ADDR : dtlr_pkg::ST_DIVLOAD;
      end
      dtlr_pkg::ST_PT_ADDR: state_next = dtlr_pkg::ST_PT_READ;
      dtlr_pkg::ST_PT_READ: state_next = dtlr_pkg::ST_PT_TEST;
      dtlr_pkg::ST_PT_TEST: begin
        state_next = (k == steps) ? dtlr_pkg::ST_FINISH : dtlr_pkg::ST_PT_ADDR;
      end
      dtlr_pkg::ST_RD_ADDR: state_next = dtlr_pkg::ST_RD_MEM;
      dtlr_pkg::ST_RD_MEM:  state_next = dtlr_pkg::ST_RD_DATA;
      dtlr_pkg::ST_RD_DATA: state_next = dtlr_pkg::ST_FINISH;
      dtlr_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = dtlr_pkg::ST_IDLE;
        end
      end
      default: state_next = dtlr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dtlr_pkg::ST_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dtlr_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end else if ((state == dtlr_pkg::ST_IDLE) && item_valid) begin
        clr_addr  <= '0;
        clr_reply <= 1'b1;
      end
    end
  end

  // Configuration writes are taken at any time.
  always_ff @(posedge clk) begin
    if (rst) begin
      area_width  <= dtlr_pkg::RESET_WIDTH;
      area_height <= dtlr_pkg::RESET_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dtlr_pkg::REG_WIDTH:  area_width  <= cfg_data;
        dtlr_pkg::REG_HEIGHT: area_height <= cfg_data[dtlr_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == dtlr_pkg::ST_FINISH) && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == dtlr_pkg::ST_FINISH) && out_free) begin
      read_color     <= res_color;
      read_depth     <= res_depth;
      pixels_written <= res_count;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      dtlr_pkg::ST_IDLE: begin
        if (item_valid) begin
          act       <= action;
          res_color <= dtlr_pkg::CLEAR_COLOR;
          res_depth <= dtlr_pkg::CLEAR_DEPTH;
          res_count <= '0;
          lane_a[0] <= VW'(start_x);
          lane_a[1] <= VW'(start_y);
          lane_a[2] <= {{(VW-8){1'b0}}, start_depth};
          lane_a[3] <= {{(VW-8){1'b0}}, start_color[23:16]};
          lane_a[4] <= {{(VW-8){1'b0}}, start_color[15:8]};
          lane_a[5] <= {{(VW-8){1'b0}}, start_color[7:0]};
          lane_b[0] <= VW'(end_x);
          lane_b[1] <= VW'(end_y);
          lane_b[2] <= {{(VW-8){1'b0}}, end_depth};
          lane_b[3] <= {{(VW-8){1'b0}}, end_color[23:16]};
          lane_b[4] <= {{(VW-8){1'b0}}, end_color[15:8]};
          lane_b[5] <= {{(VW-8){1'b0}}, end_color[7:0]};
        end
      end
      dtlr_pkg::ST_SQX: begin
        dsq <= mul_p;
      end
      dtlr_pkg::ST_SQY: begin
        dsq    <= dsq + mul_p;
        root   <= '0;
        sq_rem <= '0;
        iter   <= '0;
      end
      dtlr_pkg::ST_SQRT: begin
        dsq  <= {dsq[dtlr_pkg::SQ_W-3:0], 2'b00};
        iter <= iter + dtlr_pkg::ITER_W'(1);
        if (sq_rsh >= {2'b00, sq_trial}) begin
          sq_rem <= (SW+2)'(sq_rsh - {2'b00, sq_trial});
          root   <= {root[SW-2:0], 1'b1};
        end else begin
          sq_rem <= (SW+2)'(sq_rsh);
          root   <= {root[SW-2:0], 1'b0};
        end
      end
      dtlr_pkg::ST_ADJ: begin
        steps <= steps_next;
        sdiv  <= (steps_next == '0) ? SW'(1) : steps_next;
        k     <= '0;
        lane  <= '0;
        for (int l = 0; l < NL; l++) begin
          lane_q[l] <= lane_a[l];
          lane_r[l] <= '0;
          step_q[l] <= '0;
          step_r[l] <= '0;
        end
      end
      dtlr_pkg::ST_DIVLOAD: begin
        dvd  <= diff_mag;
        drem <= '0;
        iter <= '0;
      end
      dtlr_pkg::ST_DIV: begin
        iter <= iter + dtlr_pkg::ITER_W'(1);
        if (div_rsh >= {1'b0, steps}) begin
          drem <= SW'(div_rsh - {1'b0, steps});
          dvd  <= {dvd[VW-2:0], 1'b1};
        end else begin
          drem <= SW'(div_rsh);
          dvd  <= {dvd[VW-2:0], 1'b0};
        end
      end
      dtlr_pkg::ST_DIVFIX: begin
        // Floor division with a non-negative remainder for falling attributes.
        if (!diff_sel[VW-1]) begin
          step_q[lane] <= dvd;
          step_r[lane] <= drem;
        end else if (drem == '0) begin
          step_q[lane] <= ~dvd + VW'(1);
          step_r[lane] <= '0;
        end else begin
          step_q[lane] <= ~dvd;
          step_r[lane] <= steps - drem;
        end
        lane <= lane + dtlr_pkg::LANE_W'(1);
      end
      dtlr_pkg::ST_PT_ADDR, dtlr_pkg::ST_RD_ADDR: begin
        pt_addr  <= AW'(mul_p + (2*VW)'(pos_x[dtlr_pkg::WIDTH_W-1:0]));
        pt_ok    <= pos_in;
        pt_z     <= lane_val[2][7:0];
        pt_color <= dtlr_pkg::to_rgb565(lane_val[3][7:0], lane_val[4][7:0], lane_val[5][7:0]);
      end
      dtlr_pkg::ST_PT_TEST: begin
        if (pt_hit) begin
          res_count <= res_count + 12'd1;
        end
        k <= k + SW'(1);
        for (int l = 0; l < NL; l++) begin
          lane_q[l] <= lane_q_adv[l];
          lane_r[l] <= lane_r_adv[l];
        end
      end
      dtlr_pkg::ST_RD_DATA: begin
        if (pt_ok && (act == dtlr_pkg::ACT_READ)) begin
          res_color <= color_rd;
          res_depth <= depth_rd;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: tb/sv/depth_tested_line_rasterizer_tb.sv
// Self-checking testbench for the depth-tested line rasterizer: directed and random words,
// a scoreboard with its own frame and depth stores, and randomised idling on both channels.
// Depends on rtl/dtlr_pkg.sv and rtl/depth_tested_line_rasterizer.sv.
module depth_tested_line_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The fourth action code has no name in the package; the block must ignore it.
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 20_000_000;

  typedef struct {
    logic [1:0]         action;
    logic signed [10:0] sx, sy, ex, ey;
    logic [7:0]         sz, ez;
    logic [23:0]        sc, ec;
  } line_word_t;

  typedef struct {
    logic [15:0] color;
    logic [7:0]  depth;
    logic [11:0] written;
  } pixel_result_t;

  // Keeps its own copy of both stores and the active area, and predicts one result per word.
  class pixel_scoreboard;
    logic [15:0] frame_px[dtlr_pkg::STORE_SIZE];
    logic [7:0]  depth_px[dtlr_pkg::STORE_SIZE];
    int unsigned area_w = 320, area_h = 240;
    pixel_result_t pending[$];
    int failures = 0;
    int unsigned plotted;

    function new();
      wipe();
    endfunction

    function void wipe();
      foreach (frame_px[i]) begin
        frame_px[i] = dtlr_pkg::CLEAR_COLOR;
        depth_px[i] = dtlr_pkg::CLEAR_DEPTH;
      end
    endfunction

    function bit locate(int x, int y, output int idx);
      int w, h;
      w = (area_w > dtlr_pkg::MAX_WIDTH) ? dtlr_pkg::MAX_WIDTH : area_w;
      h = (area_h > dtlr_pkg::MAX_HEIGHT) ? dtlr_pkg::MAX_HEIGHT : area_h;
      idx = 0;
      if (x < 0 || y < 0 || x >= w || y >= h) return 0;
      idx = y * w + x;
      return idx < dtlr_pkg::STORE_SIZE;
    endfunction

    function int blend(int a, int b, int k, int s);
      longint num;
      num = longint'(a) * s + longint'(b - a) * k;
      if (num >= 0) return int'((2 * num + s) / (2 * longint'(s)));
      return -int'((-2 * num + s) / (2 * longint'(s)));
    endfunction

    function void plot(int x, int y, int z, int r, int g, int b);
      int idx;
      int r5, g6, b5;
      if (!locate(x, y, idx)) return;
      if (z >= depth_px[idx]) return;
      r5 = (r * 31 + 127) / 255;
      g6 = (g * 63 + 127) / 255;
      b5 = (b * 31 + 127) / 255;
      frame_px[idx] = 16'((r5 << 11) | (g6 << 5) | b5);
      depth_px[idx] = 8'(z);
      plotted++;
    endfunction

    function void note_word(line_word_t w);
      pixel_result_t res;
      int ax, ay, bx, by, idx;
      longint sq;
      int n;
      ax = w.sx; ay = w.sy; bx = w.ex; by = w.ey;
      res = '{dtlr_pkg::CLEAR_COLOR, dtlr_pkg::CLEAR_DEPTH, 12'd0};
      plotted = 0;
      case (w.action)
        dtlr_pkg::ACT_DRAW: begin
          sq = longint'(bx - ax) * (bx - ax) + longint'(by - ay) * (by - ay);
          n = 0;
          while (longint'(n + 1) * (n + 1) <= sq) n++;
          if (sq > longint'(n) * (n + 1)) n++;
          if (n == 0) begin
            plot(ax, ay, w.sz, w.sc[23:16], w.sc[15:8], w.sc[7:0]);
          end else begin
            for (int k = 0; k <= n; k++)
              plot(blend(ax, bx, k, n), blend(ay, by, k, n), blend(w.sz, w.ez, k, n),
                   blend(w.sc[23:16], w.ec[23:16], k, n),
                   blend(w.sc[15:8], w.ec[15:8], k, n),
                   blend(w.sc[7:0], w.ec[7:0], k, n));
          end
          res.written = 12'(plotted);
        end
        dtlr_pkg::ACT_READ: begin
          if (locate(ax, ay, idx)) begin
            res.color = frame_px[idx];
            res.depth = depth_px[idx];
          end
        end
        dtlr_pkg::ACT_CLEAR: wipe();
        default: ;
      endcase
      pending.push_back(res);
    endfunction

    function void check_result(logic [15:0] color, logic [7:0] depth, logic [11:0] written);
      pixel_result_t exp_res;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %h %h %h", color, depth, written);
        failures++;
        return;
      end
      exp_res = pending.pop_front();
      if (color !== exp_res.color) begin
        $error("read_color expected %h got %h", exp_res.color, color);
        failures++;
      end
      if (depth !== exp_res.depth) begin
        $error("read_depth expected %h got %h", exp_res.depth, depth);
        failures++;
      end
      if (written !== exp_res.written) begin
        $error("pixels_written expected %0d got %0d", exp_res.written, written);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] action = dtlr_pkg::ACT_DRAW;
  logic signed [10:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic [7:0] start_depth = '0, end_depth = '0;
  logic [23:0] start_color = '0, end_color = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [15:0] read_color;
  logic [7:0] read_depth;
  logic [11:0] pixels_written;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = dtlr_pkg::REG_WIDTH;
  logic [8:0] cfg_data = '0;

  // Idle percentages for the sender and the receiver, changed as the run goes on.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int unsigned cycles = 0;
  int clears_left = 3;
  pixel_scoreboard board = new();

  depth_tested_line_rasterizer dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // The receiver stalls at random; results are checked on the edge where a word moves.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle_pct);
    if (!rst && result_valid && !result_stall)
      board.check_result(read_color, read_depth, pixels_written);
  end

  // Watchdog: a hung block must not hang the run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL depth_tested_line_rasterizer");
      $finish;
    end
  end

  // Offers one word, with a random gap first, and holds it until the block takes it.
  // The valid stays high between back-to-back words, so it is never dropped and raised
  // again on the same edge.
  task automatic send_word(line_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid  <= 1'b1;
    action      <= w.action;
    start_x     <= w.sx;
    start_y     <= w.sy;
    start_depth <= w.sz;
    start_color <= w.sc;
    end_x       <= w.ex;
    end_y       <= w.ey;
    end_depth   <= w.ez;
    end_color   <= w.ec;
    do @(posedge clk); while (item_stall);
    board.note_word(w);
  endtask

  // Registers are only written once every expected word has come back.
  task automatic write_area(int unsigned w, int unsigned h);
    item_valid <= 1'b0;
    wait (board.pending.size() == 0);
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= dtlr_pkg::REG_WIDTH;
    cfg_data  <= 9'(w);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= dtlr_pkg::REG_HEIGHT;
    cfg_data  <= 9'(h);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.area_w = w;
    board.area_h = h & 8'hFF;
  endtask

  function automatic line_word_t make_word(logic [1:0] act, int sx, int sy, int ex, int ey,
                                           int sz, int ez, int sc, int ec);
    line_word_t w;
    w.action = act;
    w.sx = 11'(sx); w.sy = 11'(sy); w.ex = 11'(ex); w.ey = 11'(ey);
    w.sz = 8'(sz);  w.ez = 8'(ez);  w.sc = 24'(sc); w.ec = 24'(ec);
    return w;
  endfunction

  // Mostly short lines near the active area, so that reads and depth tests find
  // earlier writes; now and then a line anywhere in the full coordinate range.
  function automatic line_word_t random_word(int unsigned w, int unsigned h);
    line_word_t word;
    int pick, span_x, span_y;
    span_x = ((w > dtlr_pkg::MAX_WIDTH) ? dtlr_pkg::MAX_WIDTH : w) + 4;
    span_y = ((h > dtlr_pkg::MAX_HEIGHT) ? dtlr_pkg::MAX_HEIGHT : h) + 4;
    word.sz = 8'($urandom); word.ez = 8'($urandom);
    word.sc = 24'($urandom); word.ec = 24'($urandom);
    word.sx = 11'($urandom_range(span_x + 4) - 4);
    word.sy = 11'($urandom_range(span_y + 4) - 4);
    word.ex = word.sx + 11'($urandom_range(48) - 24);
    word.ey = word.sy + 11'($urandom_range(48) - 24);
    if ($urandom_range(99) < 5) begin
      word.sx = 11'($urandom); word.sy = 11'($urandom);
      word.ex = 11'($urandom); word.ey = 11'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 68) word.action = dtlr_pkg::ACT_DRAW;
    else if (pick < 92) word.action = dtlr_pkg::ACT_READ;
    else if (pick < 96 && clears_left > 0) begin
      word.action = dtlr_pkg::ACT_CLEAR;
      clears_left--;
    end else if (pick < 96) word.action = dtlr_pkg::ACT_READ;
    else word.action = ACT_SPARE;
    return word;
  endfunction

  initial begin
    int unsigned areas[6][2];
    int sent;
    areas = '{'{320, 240}, '{511, 255}, '{16, 12}, '{0, 7}, '{1, 1}, '{9, 0}};
    sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset area of 320 by 240.
    send_word(make_word(dtlr_pkg::ACT_DRAW, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 0));
    send_word(make_word(dtlr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    // A diagonal that runs off both corners, then the same line again so that the
    // depth test rejects what is not strictly nearer.
    send_word(make_word(dtlr_pkg::ACT_DRAW, -5, -5, 330, 250, 200, 10, 0, 24'hFFFFFF));
    send_word(make_word(dtlr_pkg::ACT_DRAW, -5, -5, 330, 250, 200, 10, 24'h123456,
                        24'hFEDCBA));
    send_word(make_word(dtlr_pkg::ACT_READ, 100, 74, 0, 0, 0, 0, 0, 0));
    send_word(make_word(dtlr_pkg::ACT_READ, 319, 239, 0, 0, 0, 0, 0, 0));
    send_word(make_word(dtlr_pkg::ACT_READ, -1, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(dtlr_pkg::ACT_READ, 320, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(dtlr_pkg::ACT_READ, 1023, 1023, 0, 0, 0, 0, 0, 0));
    send_word(make_word(dtlr_pkg::ACT_READ, -1024, -1024, 0, 0, 0, 0, 0, 0));
    send_word(make_word(ACT_SPARE, 0, 0, 5, 5, 1, 1, 24'hFFFFFF, 24'hFFFFFF));
    // Lines in the negative direction, where halves round away from zero.
    send_word(make_word(dtlr_pkg::ACT_DRAW, 10, 20, 3, 20, 0, 255, 24'h0000FF, 24'hFF0000));
    send_word(make_word(dtlr_pkg::ACT_DRAW, 30, 30, 30, 21, 255, 0, 24'h00FF00, 24'h000000));
    send_word(make_word(dtlr_pkg::ACT_DRAW, 7, 3, 2, 1, 5, 4, 24'h808080, 24'h7F7F7F));
    send_word(make_word(dtlr_pkg::ACT_READ, 30, 21, 0, 0, 0, 0, 0, 0));
    // The longest line the fields allow, corner to corner.
    send_word(make_word(dtlr_pkg::ACT_DRAW, -1024, -1024, 1023, 1023, 254, 0, 24'hFFFFFF, 0));
    send_word(make_word(dtlr_pkg::ACT_DRAW, 1023, -1024, -1024, 1023, 128, 1, 0, 24'hFFFFFF));
    send_word(make_word(dtlr_pkg::ACT_READ, 2, 2, 0, 0, 0, 0, 0, 0));
    send_word(make_word(dtlr_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(dtlr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0));

    // Random words over several areas, the extremes among them. Idling moves from a
    // busy receiver to a slow sender and then stops altogether.
    foreach (areas[p]) begin
      write_area(areas[p][0], areas[p][1]);
      repeat (34) begin
        if (sent < 68) begin
          send_idle_pct = 9;  recv_idle_pct = 54;
        end else if (sent < 136) begin
          send_idle_pct = 54; recv_idle_pct = 9;
        end else begin
          send_idle_pct = 0;  recv_idle_pct = 0;
        end
        send_word(random_word(areas[p][0], areas[p][1]));
        sent++;
      end
    end
    item_valid <= 1'b0;

    wait (board.pending.size() == 0);
    repeat (50) @(posedge clk);
    if (board.failures == 0) begin
      $display("PASS depth_tested_line_rasterizer");
    end else begin
      $display("FAIL depth_tested_line_rasterizer");
    end
    $finish;
  end
endmodule
